// ===== sv/cnd_pkg.sv =====
// Shared types, coefficients and table-building functions of the crop nitrogen demand unit.
package cnd_pkg;

   localparam int FRAC_W  = 16;
   localparam int QUO_W   = 32 + FRAC_W;
   localparam int ARR_W   = 50;
   localparam int CSR_A_W = 5;

   // configuration register indexes
   localparam logic [2:0] REG_SLA    = 3'd0;
   localparam logic [2:0] REG_FIX    = 3'd1;
   localparam logic [2:0] REG_NC_MIN = 3'd2;
   localparam logic [2:0] REG_NC_MAX = 3'd3;
   localparam logic [2:0] REG_ROOT   = 3'd4;
   localparam logic [2:0] REG_POOL   = 3'd5;
   localparam logic [2:0] REG_ORGAN  = 3'd6;

   localparam logic [25:0] K_VMAX   = 26'd41388320;
   localparam logic [25:0] CN_PLAIN = 26'd13665805;
   localparam logic [25:0] CN_FIX   = 26'd64424509;
   localparam logic [31:0] CA_PLAIN = 32'd1876900708;
   localparam logic [31:0] CA_FIX   = 32'd2993592205;

   localparam logic [60:0]      TERM_CAP = {1'b1, 60'b0};
   localparam logic [QUO_W:0]   Q_BIG    = (QUO_W + 1)'(1) << 40;
   localparam logic signed [62:0] OUT_MAX = 63'sd140737488355327;
   localparam logic signed [62:0] OUT_MIN = -63'sd140737488355328;

   localparam longint LN2_Q32 = 64'sd2977044472;

   typedef struct packed {
      logic [31:0]        max_carboxylation;
      logic signed [15:0] temperature;
      logic [31:0]        leaf_carbon;
      logic [31:0]        root_carbon;
      logic [31:0]        pool_carbon;
      logic [31:0]        organ_carbon;
      logic [31:0]        plant_density;
   } cnd_req_type;

   typedef struct packed {
      logic signed [47:0] leaf_n_demand;
      logic signed [47:0] total_n_demand;
   } cnd_rsp_type;

   function automatic logic signed [47:0] sat48(input logic signed [62:0] v);
      if (v > OUT_MAX) return OUT_MAX[47:0];
      if (v < OUT_MIN) return OUT_MIN[47:0];
      return v[47:0];
   endfunction

   // shift-subtract quotient, used only while the table is built
   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_q32(input longint x);
      longint      n;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] sum;
      if (x >= 0) n = x / LN2_Q32;
      else n = -((-x + LN2_Q32 - 1) / LN2_Q32);
      r    = 64'(x - n * LN2_Q32);
      term = 64'd1 << 32;
      sum  = term;
      for (int k = 1; k <= 16; k++) begin
         term = udiv64((term * r) >> 32, 64'(k));
         sum  = sum + term;
      end
      if (n > 24) n = 24;
      if (n >= 0) return sum << n;
      if (n < -63) return '0;
      return sum >> (-n);
   endfunction

   // Arrhenius factor at table point idx of last+1 points over -64..+64 degC, Q32
   function automatic logic [63:0] arr_entry(input int unsigned idx, input int unsigned last);
      longint      m;
      logic [63:0] d;
      logic [63:0] num;
      logic [63:0] q;
      logic [63:0] r;
      m   = longint'(last) * 8900 - longint'(idx) * 12800;
      d   = 64'd247881910 * (64'(last) * 64'd20915 + 64'(idx) * 64'd12800);
      num = 64'd6653000000 * 64'((m < 0) ? -m : m);
      q   = udiv64(num, d);
      r   = num - q * d;
      for (int b = 0; b < 32; b++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r    = r - d;
            q[0] = 1'b1;
         end
      end
      return exp_q32((m < 0) ? -longint'(q) : longint'(q));
   endfunction

endpackage

// ===== sv/cnd_divider.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module cnd_divider #(
   parameter int DEN_W = 32,
   parameter int QUO_W = 48
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [DEN_W-1:0] num_hi,
   input  logic [QUO_W-1:0] num_lo,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quotient
);

   logic [DEN_W-1:0] rem_ff  [QUO_W-1];
   logic [DEN_W-1:0] den_ff  [QUO_W-1];
   logic [QUO_W-1:0] bits_ff [QUO_W];

   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic [DEN_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] bits_src;
      logic [DEN_W:0]   trial;
      logic             fits;
      logic [QUO_W-1:0] bits_in;

      if (g == 0) begin : g_first
         assign rem_src  = num_hi;
         assign den_src  = den;
         assign bits_src = num_lo;
      end else begin : g_next
         assign rem_src  = rem_ff[g-1];
         assign den_src  = den_ff[g-1];
         assign bits_src = bits_ff[g-1];
      end

      assign trial   = {rem_src, bits_src[QUO_W-1]};
      assign fits    = trial >= {1'b0, den_src};
      assign bits_in = {bits_src[QUO_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (enable) begin
            bits_ff[g] <= bits_in;
         end
      end

      if (g < QUO_W - 1) begin : g_rem
         logic [DEN_W-1:0] rem_in;
         assign rem_in = fits ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[g] <= rem_in;
               den_ff[g] <= den_src;
            end
         end
      end
   end

   assign quotient = bits_ff[QUO_W-1];

endmodule

// ===== sv/crop_nitrogen_demand_unit.sv =====
// Crop nitrogen demand unit: top level with configuration registers and the main pipeline.
// One plant record enters per cycle while req_ready is high, and its leaf and total nitrogen
// demand leave after 63 pipeline stages plus the output register; the depth is set mostly by the
// 48-stage quotient dividers for the leaf N:C ratio and the three organ C:N quotients,
// which produce one quotient bit per stage. The Arrhenius factor comes from a constant
// table of ARRHENIUS_TABLE_ENTRIES points over -64..+64 degC, interpolated linearly.
// A two-entry output buffer lets the pipeline keep taking records while a result waits;
// req_ready drops only when both entries are full. Configuration registers sit on an
// APB-style port at byte addresses 4*i and must be written while the unit is idle.
module crop_nitrogen_demand_unit #(
   parameter int ARRHENIUS_TABLE_ENTRIES = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cnd_pkg::cnd_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cnd_pkg::cnd_rsp_type            rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cnd_pkg::CSR_A_W-1:0]     csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import cnd_pkg::*;

   localparam int IDX_W  = $clog2(ARRHENIUS_TABLE_ENTRIES);
   localparam int PNUM_W = 15 + IDX_W;
   localparam int S_ND   = 9;
   localparam int S_DIV  = S_ND + QUO_W;
   localparam int LAST   = S_DIV + 6;

   typedef logic [ARR_W-1:0] rom_type [ARRHENIUS_TABLE_ENTRIES];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i < ARRHENIUS_TABLE_ENTRIES; i++) begin
         rom[i] = ARR_W'(arr_entry(i, ARRHENIUS_TABLE_ENTRIES - 1));
      end
      return rom;
   endfunction

   localparam rom_type ARR_ROM = build_rom();

   typedef struct packed {
      logic [31:0] vmax;
      logic [31:0] leaf;
      logic [31:0] root;
      logic [31:0] pool;
      logic [31:0] organ;
      logic [31:0] nind;
      logic        nz;
   } carry_type;

   typedef struct packed {
      logic signed [47:0] nd;
      logic [31:0]        nind;
      logic               pos;
      logic               big;
   } side_type;

   // configuration
   logic [31:0] sla_ff, nc_min_ff, nc_max_ff, root_div_ff, pool_div_ff, organ_div_ff;
   logic        fix_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sla_ff       <= 32'd2294;
         fix_ff       <= 1'b0;
         nc_min_ff    <= 32'd655;
         nc_max_ff    <= 32'd6554;
         root_div_ff  <= 32'd65536;
         pool_div_ff  <= 32'd65536;
         organ_div_ff <= 32'd65536;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SLA:    sla_ff       <= csr_pwdata;
            REG_FIX:    fix_ff       <= csr_pwdata[0];
            REG_NC_MIN: nc_min_ff    <= csr_pwdata;
            REG_NC_MAX: nc_max_ff    <= csr_pwdata;
            REG_ROOT:   root_div_ff  <= csr_pwdata;
            REG_POOL:   pool_div_ff  <= csr_pwdata;
            REG_ORGAN:  organ_div_ff <= csr_pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SLA:    csr_prdata = sla_ff;
         REG_FIX:    csr_prdata = {31'b0, fix_ff};
         REG_NC_MIN: csr_prdata = nc_min_ff;
         REG_NC_MAX: csr_prdata = nc_max_ff;
         REG_ROOT:   csr_prdata = root_div_ff;
         REG_POOL:   csr_prdata = pool_div_ff;
         REG_ORGAN:  csr_prdata = organ_div_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // pipeline control: every stage advances together unless the output buffer is full
   logic            adv;
   logic [LAST:1]   vld_ff;
   logic            out_v_ff, skid_v_ff;
   cnd_rsp_type     out_ff, skid_ff, res_ff;
   logic            take, push;

   assign adv       = !skid_v_ff;
   assign req_ready = adv;
   assign take      = out_v_ff && rsp_ready;
   assign push      = adv && vld_ff[LAST];
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (adv) vld_ff <= {vld_ff[LAST-1:1], req_valid};
         if (!out_v_ff || take) begin
            out_v_ff  <= skid_v_ff || push;
            skid_v_ff <= 1'b0;
         end else if (push) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) out_ff <= skid_v_ff ? skid_ff : res_ff;
      else if (push) skid_ff <= res_ff;
   end

   // stage registers
   carry_type           car_ff [1:S_ND];
   logic [IDX_W-1:0]    idx1_ff;
   logic [14:0]         fr1_ff, fr2_ff, fr3_ff;
   logic [63:0]         ln1_ff;
   logic [ARR_W-1:0]    e0_2_ff, e1_2_ff, e0_3_ff, e0_4_ff, diff3_ff, a5_ff, sphi4_ff;
   logic [14:0]         splo4_ff;
   logic                dir3_ff, dir4_ff;
   logic [63:0]         laplo2_ff, laphi2_ff;
   logic [57:0]         t2plo2_ff, t2phi2_ff;
   logic [60:0]         la3_ff;
   logic [63:0]         t3lo4_ff;
   logic [60:0]         t3hi4_ff;
   logic [41:0]         t2_ff [3:8];
   logic [60:0]         t3_ff [5:8];
   logic [56:0]         mlo6_ff, mhi6_ff;
   logic [ARR_W-1:0]    m1_7_ff;
   logic [43:0]         p1_8_ff;
   logic signed [47:0]  nd9_ff;

   // stage 1 inputs
   logic signed [15:0]  tc;
   logic [15:0]         toff;
   logic [PNUM_W-1:0]   pnum_in;
   carry_type           car_in;

   always_comb begin
      if (req_data.temperature < -16'sd16384) tc = -16'sd16384;
      else if (req_data.temperature > 16'sd16384) tc = 16'sd16384;
      else tc = req_data.temperature;
      toff    = 16'(tc) + 16'd16384;
      pnum_in = PNUM_W'(32'(toff) * 32'(ARRHENIUS_TABLE_ENTRIES - 1));
      car_in.vmax  = req_data.max_carboxylation;
      car_in.leaf  = req_data.leaf_carbon;
      car_in.root  = req_data.root_carbon;
      car_in.pool  = req_data.pool_carbon;
      car_in.organ = req_data.organ_carbon;
      car_in.nind  = req_data.plant_density;
      car_in.nz    = (req_data.leaf_carbon != '0) && (sla_ff != '0)
                     && (req_data.plant_density != '0);
   end

   // stage 2..9 next values
   logic [IDX_W-1:0]    nxt_idx;
   logic [25:0]         cn_sel;
   logic [31:0]         ca_sel;
   logic [95:0]         la_full;
   logic [89:0]         t2_full;
   logic [63:0]         la_sh;
   logic [ARR_W-1:0]    step;
   logic [81:0]         m_full;
   logic [75:0]         p1_prod;
   logic [62:0]         pos_sum;
   logic signed [62:0]  nd_sum;
   logic signed [47:0]  nd_in;

   always_comb begin
      nxt_idx = (idx1_ff == IDX_W'(ARRHENIUS_TABLE_ENTRIES - 1)) ? idx1_ff
                                                                 : idx1_ff + 1'b1;
      cn_sel  = fix_ff ? CN_FIX : CN_PLAIN;
      ca_sel  = fix_ff ? CA_FIX : CA_PLAIN;
      la_full = {laphi2_ff, 32'b0} + 96'(laplo2_ff);
      t2_full = {t2phi2_ff, 32'b0} + 90'(t2plo2_ff);
      la_sh   = la_full[95:2*FRAC_W];
      step    = sphi4_ff + ARR_W'(splo4_ff);
      m_full  = {mhi6_ff, 25'b0} + 82'(mlo6_ff);
      p1_prod = 76'(m1_7_ff) * 76'(K_VMAX);
      pos_sum = 63'(p1_8_ff) + 63'(t2_ff[8]);
      // fixing plants subtract the area term
      nd_sum  = fix_ff ? $signed(pos_sum) - $signed({2'b0, t3_ff[8]})
                       : $signed(pos_sum) + $signed({2'b0, t3_ff[8]});
      nd_in   = car_ff[8].nz ? sat48(nd_sum) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[1] <= car_in;
         for (int k = 2; k <= S_ND; k++) car_ff[k] <= car_ff[k-1];
         // stage 1
         idx1_ff <= pnum_in[PNUM_W-1:15];
         fr1_ff  <= pnum_in[14:0];
         ln1_ff  <= 64'(req_data.leaf_carbon) * 64'(req_data.plant_density);
         // stage 2
         e0_2_ff   <= ARR_ROM[idx1_ff];
         e1_2_ff   <= ARR_ROM[nxt_idx];
         fr2_ff    <= fr1_ff;
         laplo2_ff <= 64'(ln1_ff[31:0]) * 64'(sla_ff);
         laphi2_ff <= 64'(ln1_ff[63:32]) * 64'(sla_ff);
         t2plo2_ff <= 58'(ln1_ff[31:0]) * 58'(cn_sel);
         t2phi2_ff <= 58'(ln1_ff[63:32]) * 58'(cn_sel);
         // stage 3
         e0_3_ff   <= e0_2_ff;
         dir3_ff   <= e0_2_ff >= e1_2_ff;
         diff3_ff  <= (e0_2_ff >= e1_2_ff) ? e0_2_ff - e1_2_ff : e1_2_ff - e0_2_ff;
         fr3_ff    <= fr2_ff;
         la3_ff    <= (la_sh > 64'(TERM_CAP)) ? TERM_CAP : la_sh[60:0];
         t2_ff[3]  <= t2_full[89:32+FRAC_W];
         // stage 4
         e0_4_ff   <= e0_3_ff;
         dir4_ff   <= dir3_ff;
         sphi4_ff  <= ARR_W'(diff3_ff[ARR_W-1:15]) * ARR_W'(fr3_ff);
         splo4_ff  <= 15'((30'(diff3_ff[14:0]) * 30'(fr3_ff)) >> 15);
         t3lo4_ff  <= 64'(la3_ff[31:0]) * 64'(ca_sel);
         t3hi4_ff  <= 61'(la3_ff[60:32]) * 61'(ca_sel);
         for (int k = 4; k <= 8; k++) t2_ff[k] <= t2_ff[k-1];
         // stage 5
         a5_ff     <= dir4_ff ? e0_4_ff - step : e0_4_ff + step;
         t3_ff[5]  <= t3hi4_ff + 61'(t3lo4_ff[63:32]);
         for (int k = 6; k <= 8; k++) t3_ff[k] <= t3_ff[k-1];
         // stage 6
         mlo6_ff   <= 57'(car_ff[5].vmax) * 57'(a5_ff[24:0]);
         mhi6_ff   <= 57'(car_ff[5].vmax) * 57'(a5_ff[ARR_W-1:25]);
         // stage 7, 8, 9
         m1_7_ff   <= m_full[81:32];
         p1_8_ff   <= p1_prod[75:32];
         nd9_ff    <= nd_in;
      end
   end

   // quotient section
   side_type          side_in;
   side_type          side_ff [QUO_W];
   logic [QUO_W-1:0]  q_ratio, q_root, q_pool, q_organ;

   always_comb begin
      side_in.nd   = nd9_ff;
      side_in.nind = car_ff[S_ND].nind;
      side_in.pos  = (car_ff[S_ND].leaf != '0) && (nd9_ff > 48'sd0);
      side_in.big  = 32'(nd9_ff[46:32]) >= car_ff[S_ND].leaf;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < QUO_W; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   cnd_divider #(.DEN_W(32), .QUO_W(QUO_W)) u_div_ratio (
      .clock    (clock),
      .enable   (adv),
      .num_hi   (32'(nd9_ff[46:32])),
      .num_lo   ({nd9_ff[31:0], FRAC_W'(0)}),
      .den      (car_ff[S_ND].leaf),
      .quotient (q_ratio)
   );

   cnd_divider #(.DEN_W(32), .QUO_W(QUO_W)) u_div_root (
      .clock    (clock),
      .enable   (adv),
      .num_hi   (32'b0),
      .num_lo   ({car_ff[S_ND].root, FRAC_W'(0)}),
      .den      (root_div_ff),
      .quotient (q_root)
   );

   cnd_divider #(.DEN_W(32), .QUO_W(QUO_W)) u_div_pool (
      .clock    (clock),
      .enable   (adv),
      .num_hi   (32'b0),
      .num_lo   ({car_ff[S_ND].pool, FRAC_W'(0)}),
      .den      (pool_div_ff),
      .quotient (q_pool)
   );

   cnd_divider #(.DEN_W(32), .QUO_W(QUO_W)) u_div_organ (
      .clock    (clock),
      .enable   (adv),
      .num_hi   (32'b0),
      .num_lo   ({car_ff[S_ND].organ, FRAC_W'(0)}),
      .den      (organ_div_ff),
      .quotient (q_organ)
   );

   // tail stages
   side_type            tail_ff [5];
   logic [31:0]         ratio_ff;
   logic [61:0]         s_ff;
   logic [63:0]         xlo_ff, ylo_ff;
   logic [61:0]         xhi_ff;
   logic [60:0]         yhi_ff;
   logic [60:0]         x_ff, y_ff;

   side_type            sd;
   logic [QUO_W:0]      q;
   logic [31:0]         ratio_in;
   logic [60:0]         oq_root, oq_pool, oq_organ;
   logic [93:0]         x_full;
   logic [92:0]         y_full;
   logic [77:0]         x_sh;
   logic [76:0]         y_sh;
   logic signed [62:0]  tot_sum;

   always_comb begin
      sd = side_ff[QUO_W-1];
      if (!sd.pos) q = '0;
      else if (sd.big) q = Q_BIG;
      else q = {1'b0, q_ratio};
      // max is tested first, so with an inverted range a ratio above max lands on max, any other on min
      if (!sd.nd[47] && q > (QUO_W + 1)'(nc_max_ff)) ratio_in = nc_max_ff;
      else if (sd.nd[47] || q < (QUO_W + 1)'(nc_min_ff)) ratio_in = nc_min_ff;
      else ratio_in = q[31:0];
      oq_root  = (root_div_ff == '0) ? TERM_CAP : 61'(q_root);
      oq_pool  = (pool_div_ff == '0) ? TERM_CAP : 61'(q_pool);
      oq_organ = (organ_div_ff == '0) ? TERM_CAP : 61'(q_organ);
      x_full   = {xhi_ff, 32'b0} + 94'(xlo_ff);
      x_sh     = x_full[93:FRAC_W];
      y_full   = {yhi_ff, 32'b0} + 93'(ylo_ff);
      y_sh     = y_full[92:FRAC_W];
      tot_sum  = 63'(tail_ff[4].nd) + $signed({2'b0, y_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tail_ff[0] <= sd;
         for (int k = 1; k < 5; k++) tail_ff[k] <= tail_ff[k-1];
         ratio_ff <= ratio_in;
         s_ff     <= 62'(oq_root) + 62'(oq_pool) + 62'(oq_organ);
         xlo_ff   <= 64'(ratio_ff) * 64'(s_ff[31:0]);
         xhi_ff   <= 62'(ratio_ff) * 62'(s_ff[61:32]);
         x_ff     <= (x_sh > 78'(TERM_CAP)) ? TERM_CAP : x_sh[60:0];
         ylo_ff   <= 64'(x_ff[31:0]) * 64'(tail_ff[2].nind);
         yhi_ff   <= 61'(x_ff[60:32]) * 61'(tail_ff[2].nind);
         y_ff     <= (y_sh > 77'(TERM_CAP)) ? TERM_CAP : y_sh[60:0];
         res_ff.leaf_n_demand  <= tail_ff[4].nd;
         res_ff.total_n_demand <= sat48(tot_sum);
      end
   end

endmodule

// ===== tb/tb_crop_nitrogen_demand_unit.sv =====
// Self-checking testbench for the crop nitrogen demand unit: directed table, then random records.
`timescale 1ns / 100ps

module tb_crop_nitrogen_demand_unit;
   import cnd_pkg::*;

   localparam int          LUT_N     = 128;
   localparam int          FB        = 16;
   localparam logic [63:0] CAP       = 64'h1000_0000_0000_0000;
   localparam logic [63:0] C_K       = 64'd41388320;
   localparam logic [63:0] C_N_PLAIN = 64'd13665805;
   localparam logic [63:0] C_N_FIX   = 64'd64424509;
   localparam logic [63:0] C_A_PLAIN = 64'd1876900708;
   localparam logic [63:0] C_A_FIX   = 64'd2993592205;
   localparam longint      LN2       = 64'sd2977044472;
   localparam longint      SAT_HI    = 64'sd140737488355327;
   localparam longint      SAT_LO    = -64'sd140737488355328;
   localparam int          STALL_MAX = 2000;

   typedef struct {
      cnd_req_type rec;
      bit          typed;
      logic [47:0] leaf_exp;
      logic [47:0] total_exp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cnd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cnd_rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_A_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   crop_nitrogen_demand_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [63:0] arr_lut [LUT_N];
   logic [31:0] cfg_sla, cfg_nc_min, cfg_nc_max, cfg_root_div, cfg_pool_div, cfg_organ_div;
   bit          cfg_fix;
   cnd_rsp_type demand_q [$];
   int          fail_cnt = 0;
   int          idle_cycles = 0;
   bit          tx_burst = 0, rx_burst = 0;

   function automatic logic [63:0] exp_fix(input longint x);
      longint      n;
      logic [63:0] r, term, sum;
      if (x >= 0) n = x / LN2;
      else n = -((-x + LN2 - 1) / LN2);
      r    = 64'(x - n * LN2);
      term = 64'd1 << 32;
      sum  = term;
      for (int k = 1; k <= 16; k++) begin
         term = ((term * r) >> 32) / 64'(k);
         sum  = sum + term;
      end
      if (n > 24) n = 24;
      if (n >= 0) return sum << n;
      if (n < -63) return '0;
      return sum >> (-n);
   endfunction

   function automatic void build_lut();
      longint      m;
      logic [63:0] d, num, q, r, n1;
      n1 = LUT_N - 1;
      for (int i = 0; i < LUT_N; i++) begin
         m   = longint'(8900 * n1) - longint'(12800 * i);
         d   = 64'd247881910 * (64'd20915 * n1 + 64'd12800 * 64'(i));
         num = 64'd6653000000 * 64'((m < 0) ? -m : m);
         q   = num / d;
         r   = num % d;
         for (int b = 0; b < 32; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
               r    = r - d;
               q[0] = 1'b1;
            end
         end
         arr_lut[i] = exp_fix((m < 0) ? -longint'(q) : longint'(q));
      end
   endfunction

   function automatic logic [63:0] arrh_factor(input int t);
      logic [63:0] pnum, idx, fr, e0, e1, diff, step;
      if (t < -16384) t = -16384;
      if (t > 16384) t = 16384;
      pnum = 64'(t + 16384) * (LUT_N - 1);
      idx  = pnum >> 15;
      fr   = pnum & 64'h7FFF;
      if (idx >= LUT_N - 1) return arr_lut[LUT_N-1];
      e0   = arr_lut[idx];
      e1   = arr_lut[idx+1];
      diff = (e0 >= e1) ? e0 - e1 : e1 - e0;
      step = (diff >> 15) * fr + (((diff & 64'h7FFF) * fr) >> 15);
      return (e0 >= e1) ? e0 - step : e0 + step;
   endfunction

   function automatic logic [63:0] msat(input logic [63:0] a, input logic [63:0] b, input int s);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      p = p >> s;
      if (p > {64'b0, CAP}) return CAP;
      return p[63:0];
   endfunction

   function automatic longint clip48(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic logic [63:0] organ_share(input logic [31:0] c, input logic [31:0] dv);
      if (dv == 0) return CAP;
      return ({32'b0, c} << FB) / {32'b0, dv};
   endfunction

   function automatic cnd_rsp_type predict_demand(input cnd_req_type r);
      logic [63:0] leaf, dens, ln, p1, t2, la, t3, q, ip, rem, ratio, s, x, y;
      longint      nd;
      cnd_rsp_type o;
      leaf = r.leaf_carbon;
      dens = r.plant_density;
      nd   = 0;
      q    = 0;
      if (leaf != 0 && cfg_sla != 0 && dens != 0) begin
         p1 = msat(msat(r.max_carboxylation, arrh_factor(int'(r.temperature)), 32), C_K, 32);
         ln = leaf * dens;
         t2 = msat(ln, cfg_fix ? C_N_FIX : C_N_PLAIN, 32 + FB);
         la = msat(ln, cfg_sla, 2 * FB);
         t3 = msat(la, cfg_fix ? C_A_FIX : C_A_PLAIN, 32);
         nd = longint'(p1) + longint'(t2) + (cfg_fix ? -longint'(t3) : longint'(t3));
         nd = clip48(nd);
      end
      if (leaf != 0 && nd > 0) begin
         ip  = 64'(nd) / leaf;
         rem = 64'(nd) % leaf;
         if (ip >= 64'h1_0000_0000) q = 64'd1 << 40;
         else q = (ip << FB) + ((rem << FB) / leaf);
      end
      // max test first, so when the bounds cross max wins above max and min wins elsewhere
      if (nd >= 0 && q > cfg_nc_max) ratio = cfg_nc_max;
      else if (nd < 0 || q < cfg_nc_min) ratio = cfg_nc_min;
      else ratio = q;
      s = organ_share(r.root_carbon, cfg_root_div) + organ_share(r.pool_carbon, cfg_pool_div)
          + organ_share(r.organ_carbon, cfg_organ_div);
      x = msat(ratio, s, FB);
      y = msat(x, dens, FB);
      o.leaf_n_demand  = nd[47:0];
      o.total_n_demand = 48'(clip48(nd + longint'(y)));
      return o;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= CSR_A_W'({idx, 2'b00});
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SLA:    cfg_sla       = val;
         REG_FIX:    cfg_fix       = val[0];
         REG_NC_MIN: cfg_nc_min    = val;
         REG_NC_MAX: cfg_nc_max    = val;
         REG_ROOT:   cfg_root_div  = val;
         REG_POOL:   cfg_pool_div  = val;
         REG_ORGAN:  cfg_organ_div = val;
         default: ;
      endcase
   endtask

   task automatic drain_demands();
      while (demand_q.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   // hold valid and payload until the beat is taken, then queue the expectation
   task automatic send_record(input cnd_req_type r, input bit typed,
                              input logic [47:0] leaf_exp, input logic [47:0] total_exp);
      int          gap;
      cnd_rsp_type e;
      gap = tx_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) begin
         e.leaf_n_demand  = leaf_exp;
         e.total_n_demand = total_exp;
      end else begin
         e = predict_demand(r);
      end
      demand_q.push_back(e);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         4:       return $urandom_range(1, 32'h0000_FFFF);
         default: return $urandom_range(32'h0000_1000, 32'h0040_0000);
      endcase
   endfunction

   function automatic cnd_req_type rand_record();
      cnd_req_type r;
      r.max_carboxylation = rand_word();
      r.temperature       = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 32768) - 16384);
      r.leaf_carbon       = rand_word();
      r.root_carbon       = rand_word();
      r.pool_carbon       = rand_word();
      r.organ_carbon      = rand_word();
      r.plant_density     = rand_word();
      return r;
   endfunction

   function automatic cnd_req_type mk(input logic [31:0] vm, input logic [15:0] t,
                                      input logic [31:0] lf, input logic [31:0] rt,
                                      input logic [31:0] pl, input logic [31:0] og,
                                      input logic [31:0] dn);
      cnd_req_type r;
      r = '{vm, t, lf, rt, pl, og, dn};
      return r;
   endfunction

   task automatic load_config(input logic [31:0] sla, input logic [31:0] fx,
                              input logic [31:0] nmin, input logic [31:0] nmax,
                              input logic [31:0] rd, input logic [31:0] pd,
                              input logic [31:0] od);
      csr_write(REG_SLA, sla);
      csr_write(REG_FIX, fx);
      csr_write(REG_NC_MIN, nmin);
      csr_write(REG_NC_MAX, nmax);
      csr_write(REG_ROOT, rd);
      csr_write(REG_POOL, pd);
      csr_write(REG_ORGAN, od);
   endtask

   // check each result beat against the oldest expectation
   always begin : rsp_side
      int          gap;
      cnd_rsp_type e;
      gap = rx_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         rsp_ready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rsp_ready <= 1'b1;
      @(posedge clock);
      while (!rsp_valid) @(posedge clock);
      if ($urandom_range(0, 40) == 0) rx_burst = !rx_burst;
      if (demand_q.size() == 0) begin
         fail_cnt++;
         if (fail_cnt <= 10) $display("unexpected result beat %h", rsp_data);
      end else begin
         e = demand_q.pop_front();
         if (rsp_data.leaf_n_demand !== e.leaf_n_demand) begin
            fail_cnt++;
            if (fail_cnt <= 10)
               $display("leaf_n_demand: expected %h, got %h", e.leaf_n_demand,
                        rsp_data.leaf_n_demand);
         end
         if (rsp_data.total_n_demand !== e.total_n_demand) begin
            fail_cnt++;
            if (fail_cnt <= 10)
               $display("total_n_demand: expected %h, got %h", e.total_n_demand,
                        rsp_data.total_n_demand);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stim
      stim_row_type rows [$];
      build_lut();
      cfg_sla = 2294; cfg_fix = 0; cfg_nc_min = 655; cfg_nc_max = 6554;
      cfg_root_div = 65536; cfg_pool_div = 65536; cfg_organ_div = 65536;

      // zero leaf carbon or density: no leaf demand, and no organs gives no total
      rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1, 48'h0, 48'h0});
      rows.push_back('{mk('1, 16'sd6400, '1, 0, 0, 0, 0), 1, 48'h0, 48'h0});
      rows.push_back('{mk('1, 16'sd6400, 0, '1, '1, '1, '1), 0, 0, 0});
      rows.push_back('{mk('1, 16'sd16384, '1, '1, '1, '1, '1), 0, 0, 0});
      rows.push_back('{mk('1, -16'sd16384, '1, '1, '1, '1, '1), 0, 0, 0});
      rows.push_back('{mk(32'h0010_0000, 16'h7FFF, 32'h1_0000, 32'h1_0000, 0, 0, 32'h1_0000),
                       0, 0, 0});
      rows.push_back('{mk(32'h0010_0000, 16'h8000, 32'h1_0000, 0, 32'h1_0000, 0, 32'h1_0000),
                       0, 0, 0});
      rows.push_back('{mk(32'h0010_0000, 16'sd6400, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1_0000),
                       0, 0, 0});
      rows.push_back('{mk(32'h0020_0000, 16'sd2560, 32'h0000_0001, 32'h8000, 32'h8000,
                          32'h8000, 32'h0000_0001), 0, 0, 0});
      rows.push_back('{mk(32'h0020_0000, -16'sd2560, 32'h0004_0000, 32'h8000, 32'h8000,
                          32'h8000, 32'h0008_0000), 0, 0, 0});
      rows.push_back('{mk(0, 16'sd0, 32'h0100_0000, 32'h100, 32'h100, 32'h100, 32'h0002_0000),
                       0, 0, 0});
      rows.push_back('{mk(32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555), 0, 0, 0});
      rows.push_back('{mk(32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA), 0, 0, 0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_record(rows[i].rec, rows[i].typed, rows[i].leaf_exp,
                                    rows[i].total_exp);
      req_valid <= 1'b0;

      for (int ph = 0; ph < 7; ph++) begin
         drain_demands();
         case (ph)
            0: load_config(1, 1, 0, '1, 1, 1, 1);
            1: load_config('1, 1, 32'h0001_0000, 32'h100, '1, '1, '1);  // crossed bounds
            2: load_config(2294, 0, 655, 6554, 0, 0, 0);                 // zero divisors
            3: load_config('1, 0, '1, '1, 65536, 65536, 65536);
            default: load_config($urandom_range(1, 32'h0002_0000), $urandom, $urandom_range(0, 8000),
                                 $urandom_range(0, 80000), $urandom_range(1, 32'h0004_0000),
                                 $urandom, $urandom_range(1, 32'h0004_0000));
         endcase
         tx_burst = ph[0];
         for (int n = 0; n < 100; n++) begin
            if (n == 50 && ph == 3) begin
               req_valid <= 1'b0;
               while (demand_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 30) == 0) tx_burst = !tx_burst;
            send_record(rand_record(), 0, 0, 0);
         end
         req_valid <= 1'b0;
      end

      drain_demands();
      if (fail_cnt == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
